@@ rtl/core/irpe_pkg.sv @@
// Shared types and constants for the IR pulse train encoder.
// Used by irpe_ctrl, irpe_datapath and the top level; no dependencies.
package irpe_pkg;

  // Encoding modes
  localparam logic [1:0] MODE_DIST  = 2'd0;
  localparam logic [1:0] MODE_WIDTH = 2'd1;
  localparam logic [1:0] MODE_RC5   = 2'd2;
  localparam logic [1:0] MODE_RC6   = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TIME   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_EN   = 3'd6;

  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 17;
  localparam int CODE_W     = 48;
  localparam int BCNT_W     = 6;

  // Register reset values
  localparam logic [15:0] RST_HDR_MARK  = 16'd8000;
  localparam logic [15:0] RST_HDR_SPACE = 16'd4000;
  localparam logic [15:0] RST_UNIT_TIME = 16'd600;
  localparam logic [15:0] RST_ONE_TIME  = 16'd1600;
  localparam logic [15:0] RST_ZERO_TIME = 16'd550;

  // Kind of segment pair the datapath builds
  typedef enum logic [1:0] {
    PK_HEADER,     // header mark, header space
    PK_UNIT_PAIR,  // unit mark, unit space
    PK_UNIT_MARK,  // unit mark, no second segment
    PK_DATA        // one code bit, mode dependent
  } pair_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    pair_kind_t kind;
    logic       last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       footer_en;
    logic       skip;
    logic       n_zero;
    logic       pos_zero;
  } dp_stat_t;

endpackage

@@ rtl/core/irpe_ctrl.sv @@
// Frame sequencer for the IR pulse train encoder.
// Walks header, start, data and footer phases; depends on irpe_pkg.
module irpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  irpe_pkg::dp_stat_t stat,
  output irpe_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_HDR,
    S_ST1,
    S_ST2,
    S_BITS,
    S_FTR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   ftr_on;

  // footer only exists in the two pulse modes
  assign ftr_on = stat.footer_en &&
                  (stat.mode == irpe_pkg::MODE_DIST || stat.mode == irpe_pkg::MODE_WIDTH);

  // next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.mode == irpe_pkg::MODE_RC5)      state_nxt = S_ST1;
        else if (!stat.skip)                      state_nxt = S_HDR;
        else if (stat.mode == irpe_pkg::MODE_RC6) state_nxt = S_ST1;
        else if (!stat.n_zero)                    state_nxt = S_BITS;
        else if (ftr_on)                          state_nxt = S_FTR;
        else                                      state_nxt = S_IDLE;
      end
      S_HDR: begin
        if (stat.mode == irpe_pkg::MODE_RC6) state_nxt = S_ST1;
        else if (!stat.n_zero)               state_nxt = S_BITS;
        else if (ftr_on)                     state_nxt = S_FTR;
        else                                 state_nxt = S_IDLE;
      end
      S_ST1: begin
        if (stat.mode == irpe_pkg::MODE_RC5) state_nxt = S_ST2;
        else if (!stat.n_zero)               state_nxt = S_BITS;
        else                                 state_nxt = S_IDLE;
      end
      S_ST2: begin
        state_nxt = stat.n_zero ? S_IDLE : S_BITS;
      end
      S_BITS: begin
        if (stat.pos_zero) state_nxt = ftr_on ? S_FTR : S_IDLE;
      end
      S_FTR: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy_nxt = (state_nxt != S_IDLE);

  // commands decoded from the current phase
  always_comb begin
    cmd      = '0;
    cmd.load = (state_r == S_LOAD);
    cmd.last = (state_nxt == S_IDLE);
    unique case (state_r)
      S_HDR:   begin cmd.emit = 1'b1; cmd.kind = irpe_pkg::PK_HEADER;    end
      S_ST1:   begin cmd.emit = 1'b1; cmd.kind = irpe_pkg::PK_UNIT_PAIR; end
      S_ST2:   begin cmd.emit = 1'b1; cmd.kind = irpe_pkg::PK_UNIT_MARK; end
      S_BITS:  begin cmd.emit = 1'b1; cmd.kind = irpe_pkg::PK_DATA;      end
      S_FTR:   begin cmd.emit = 1'b1; cmd.kind = irpe_pkg::PK_UNIT_MARK; end
      default: begin cmd.emit = 1'b0; cmd.kind = irpe_pkg::PK_HEADER;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/core/irpe_datapath.sv @@
// Datapath of the IR pulse train encoder: configuration registers,
// code word and bit counters, and the registered result. Depends on irpe_pkg.
module irpe_datapath #(
  parameter int MAX_CODE_BITS    = 48,
  parameter int DOUBLE_BIT_INDEX = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write
  input  logic                                 cfg_we,
  input  logic [irpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [irpe_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input transaction
  input  logic                                 in_take,
  input  logic [irpe_pkg::CODE_W-1:0]          in_code_word,
  input  logic [irpe_pkg::BCNT_W-1:0]          in_bit_count,
  input  logic                                 in_skip_header,
  // control
  input  irpe_pkg::ctrl_cmd_t                  cmd,
  output irpe_pkg::dp_stat_t                   stat,
  // result
  output logic                                 out_valid,
  output logic                                 out_first_is_mark,
  output logic [irpe_pkg::TIME_W-1:0]          out_first_time_us,
  output logic [irpe_pkg::TIME_W-1:0]          out_second_time_us,
  output logic                                 out_last_pair
);

  localparam int CW = $clog2(MAX_CODE_BITS + 1);
  localparam int IW = $clog2(MAX_CODE_BITS);
  localparam int EW = (MAX_CODE_BITS > irpe_pkg::CODE_W) ? MAX_CODE_BITS : irpe_pkg::CODE_W;
  localparam int TW = irpe_pkg::TIME_W;

  // configuration
  logic [1:0]  mode_r;
  logic [15:0] hdr_mark_r, hdr_space_r, unit_r, one_r, zero_r;
  logic        footer_en_r;

  // frame data
  logic [EW-1:0]               code_ext;
  logic [MAX_CODE_BITS-1:0]    code_r;
  logic                        skip_in_r, skip_r;
  logic [irpe_pkg::BCNT_W-1:0] bc_in_r;
  logic [6:0]                  bc7, n7;
  logic [CW-1:0]               n, n_m1;
  logic                        n_zero_r;
  logic [IW-1:0]               pos_r, idx_r;
  logic [EW-1:0]               code_in_r;

  // result
  logic          valid_r;
  logic          mark_r, mark_nxt;
  logic [TW-1:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic          last_r;

  logic          bit_val, dbl;
  logic [TW-1:0] unit_t, one_t, zero_t, hm_t, hs_t, dbl_t;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= irpe_pkg::MODE_DIST;
      hdr_mark_r  <= irpe_pkg::RST_HDR_MARK;
      hdr_space_r <= irpe_pkg::RST_HDR_SPACE;
      unit_r      <= irpe_pkg::RST_UNIT_TIME;
      one_r       <= irpe_pkg::RST_ONE_TIME;
      zero_r      <= irpe_pkg::RST_ZERO_TIME;
      footer_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irpe_pkg::CFG_MODE:      mode_r      <= cfg_data[1:0];
        irpe_pkg::CFG_HDR_MARK:  hdr_mark_r  <= cfg_data;
        irpe_pkg::CFG_HDR_SPACE: hdr_space_r <= cfg_data;
        irpe_pkg::CFG_UNIT_TIME: unit_r      <= cfg_data;
        irpe_pkg::CFG_ONE_TIME:  one_r       <= cfg_data;
        irpe_pkg::CFG_ZERO_TIME: zero_r      <= cfg_data;
        irpe_pkg::CFG_FOOTER_EN: footer_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // capture the transaction as it is accepted
  assign code_ext = EW'(in_code_word);

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_in_r <= code_ext;
      bc_in_r   <= in_bit_count;
      skip_in_r <= in_skip_header;
    end
  end

  // bit count saturates at the code register size
  assign bc7  = 7'(bc_in_r);
  assign n7   = (bc7 > 7'(MAX_CODE_BITS)) ? 7'(MAX_CODE_BITS) : bc7;
  assign n    = n7[CW-1:0];
  assign n_m1 = n - CW'(1);

  // load the frame, then step one bit per data pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r   <= code_in_r[MAX_CODE_BITS-1:0];
      skip_r   <= skip_in_r;
      n_zero_r <= (n == '0);
      pos_r    <= n_m1[IW-1:0];
      idx_r    <= '0;
    end else if (cmd.emit && cmd.kind == irpe_pkg::PK_DATA) begin
      pos_r <= pos_r - IW'(1);
      idx_r <= idx_r + IW'(1);
    end
  end

  // status; skip is read in the load cycle, so it comes straight from capture
  always_comb begin
    stat.mode      = mode_r;
    stat.footer_en = footer_en_r;
    stat.skip      = cmd.load ? skip_in_r : skip_r;
    stat.n_zero    = cmd.load ? (n == '0) : n_zero_r;
    stat.pos_zero  = (pos_r == '0);
  end

  // pair values
  assign bit_val = code_r[pos_r];
  assign dbl     = (7'(idx_r) == 7'(DOUBLE_BIT_INDEX - 1));
  assign unit_t  = TW'(unit_r);
  assign one_t   = TW'(one_r);
  assign zero_t  = TW'(zero_r);
  assign hm_t    = TW'(hdr_mark_r);
  assign hs_t    = TW'(hdr_space_r);
  assign dbl_t   = dbl ? {unit_r, 1'b0} : unit_t;

  always_comb begin
    mark_nxt = 1'b1;
    t1_nxt   = unit_t;
    t2_nxt   = unit_t;
    case (cmd.kind)
      irpe_pkg::PK_HEADER: begin
        t1_nxt = hm_t;
        t2_nxt = hs_t;
      end
      irpe_pkg::PK_UNIT_PAIR: ;
      irpe_pkg::PK_UNIT_MARK: begin
        t2_nxt = '0;
      end
      irpe_pkg::PK_DATA: begin
        case (mode_r)
          irpe_pkg::MODE_DIST: begin
            t2_nxt = bit_val ? one_t : zero_t;
          end
          irpe_pkg::MODE_WIDTH: begin
            t1_nxt = bit_val ? one_t : unit_t;
            t2_nxt = zero_t;
          end
          irpe_pkg::MODE_RC5: begin
            mark_nxt = ~bit_val;
          end
          default: begin
            mark_nxt = bit_val;
            t1_nxt   = dbl_t;
            t2_nxt   = dbl_t;
          end
        endcase
      end
      default: ;
    endcase
  end

  // result register, one strobe per pair
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mark_r <= mark_nxt;
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      last_r <= cmd.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_first_is_mark  = mark_r;
  assign out_first_time_us  = t1_r;
  assign out_second_time_us = t2_r;
  assign out_last_pair      = last_r;

endmodule

@@ rtl/core/ir_remote_pulse_train_encoder_unit.sv @@
// IR remote pulse train encoder: top level joining sequencer and datapath.
// Depends on irpe_pkg, irpe_ctrl and irpe_datapath.
//
// A frame is accepted when start is high and busy is low. The S_LOAD state
// then loads the frame, and from then on one segment pair is produced every
// cycle, each shown for a single cycle with out_valid high; the receiver
// cannot stall, so it must take a pair on every strobe. out_last_pair marks
// the final pair. Busy stays high from the load state through the final
// pair; the rate is set by the sequencer emitting one pair per cycle. A
// frame that produces no pairs still takes the load cycle. Write
// configuration only while busy is low and no strobe is pending; cfg_ready
// is always high.
module ir_remote_pulse_train_encoder_unit #(
  parameter int MAX_CODE_BITS    = 48,
  parameter int DOUBLE_BIT_INDEX = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            start,
  output logic                            busy,
  input  logic [irpe_pkg::CODE_W-1:0]     in_code_word,
  input  logic [irpe_pkg::BCNT_W-1:0]     in_bit_count,
  input  logic                            in_skip_header,
  // result
  output logic                            out_valid,
  output logic                            out_first_is_mark,
  output logic [irpe_pkg::TIME_W-1:0]     out_first_time_us,
  output logic [irpe_pkg::TIME_W-1:0]     out_second_time_us,
  output logic                            out_last_pair,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpe_pkg::CFG_DATA_W-1:0] cfg_data
);

  irpe_pkg::ctrl_cmd_t cmd;
  irpe_pkg::dp_stat_t  stat;
  logic                in_take;

  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;

  irpe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  irpe_datapath #(
    .MAX_CODE_BITS    (MAX_CODE_BITS),
    .DOUBLE_BIT_INDEX (DOUBLE_BIT_INDEX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_take            (in_take),
    .in_code_word       (in_code_word),
    .in_bit_count       (in_bit_count),
    .in_skip_header     (in_skip_header),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_first_is_mark  (out_first_is_mark),
    .out_first_time_us  (out_first_time_us),
    .out_second_time_us (out_second_time_us),
    .out_last_pair      (out_last_pair)
  );

endmodule
